FILE: src/mpct_pkg.sv
// shared types and constants for the message port credit table
package mpct_pkg;

   localparam int HANDLE_W      = 8;
   localparam int HANDLE_SPACE  = 256;
   localparam int MAX_MSG_W     = 16;
   localparam int SLOTS_DEFAULT = 256;
   localparam int COUNT_W_DEFAULT = 16;
   localparam int GROUP_SIZE    = 16;
   localparam int GROUP_W       = 4;

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_SEND    = 2'd2,
      CMD_RECEIVE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BLOCK   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      command_type             command;
      logic [HANDLE_W-1:0]     port_index;
      logic [MAX_MSG_W-1:0]    msg_limit;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [HANDLE_W-1:0]     handle;
   } rsp_type;

   typedef struct packed {
      logic                    found;
      logic [HANDLE_W-1:0]     slot;
   } free_slot_type;

endpackage

FILE: src/message_port_credit_table.sv
// message port credit table: create, destroy, send and receive on a table of ports
//
// Usage: drive req_item and raise start; the item is taken at a rising edge
// where start is high and busy is low. busy is high for the cycle after that
// edge, while the slot entry is read, updated and written back.
// Each item gives exactly one result on rsp_item, shown for one cycle with
// rsp_strobe high, in the cycle after the update. The receiver cannot hold
// results off and need not: there is one result per item.
// Accept edge to strobe: request and read registers, then result registers.
// No new item is taken while busy is high, as the limit/count memory is read
// at the accept edge and the same entry is written back in the update cycle.
// Create returns the lowest free slot; the search runs as a registered
// group stage plus a final pick in the update cycle.
// Reset (synchronous, active high) frees every slot at once through the
// in-use flip-flops; limits and counts are not cleared, since a slot's entry
// is always written by create before it can be read. busy is high in reset.
module message_port_credit_table import mpct_pkg::*; #(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_W_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int LIVE  = (SLOTS < HANDLE_SPACE) ? SLOTS : HANDLE_SPACE;
   localparam int IDX_W = $clog2(LIVE);
   localparam int LIM_W = (COUNT_WIDTH < MAX_MSG_W) ? COUNT_WIDTH : MAX_MSG_W;
   localparam logic [HANDLE_W:0] LIVE_VEC = (HANDLE_W + 1)'(LIVE);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] limit;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   entry_type           slot_mem [LIVE];
   entry_type           rd_ff;
   req_type             req_ff;
   logic                busy_ff;
   logic [LIVE-1:0]     in_use_ff;
   logic [LIVE-1:0]     in_use_in;
   logic                rsp_strobe_ff;
   rsp_type             rsp_item_ff;
   rsp_type             rsp_item_in;

   logic                accept;
   logic                idx_ok;
   logic                live;
   logic [IDX_W-1:0]    idx;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [COUNT_WIDTH-1:0] new_limit;
   free_slot_type       free_slot;

   assign accept = start && !busy_ff && !reset;
   assign busy   = busy_ff || reset;

   mpct_free_finder #(
      .LIVE (LIVE)
   ) u_finder (
      .clock     (clock),
      .in_use    (in_use_ff),
      .free_slot (free_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         in_use_ff     <= '0;
      end else begin
         busy_ff       <= accept;
         rsp_strobe_ff <= busy_ff;
         in_use_ff     <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (busy_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // limit/count store, one read port and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_ff <= slot_mem[req_item.port_index[IDX_W-1:0]];
      end
   end

   assign idx       = req_ff.port_index[IDX_W-1:0];
   assign idx_ok    = ({1'b0, req_ff.port_index} < LIVE_VEC);
   assign live      = idx_ok && in_use_ff[idx];
   assign new_limit = COUNT_WIDTH'(req_ff.msg_limit[LIM_W-1:0]);

   // update cycle: decide the result and write the entry back
   always_comb begin
      in_use_in          = in_use_ff;
      rsp_item_in.status = ST_OK;
      rsp_item_in.handle = '0;
      mem_we             = 1'b0;
      mem_waddr          = idx;
      mem_wdata          = rd_ff;
      if (busy_ff) begin
         unique case (req_ff.command)
            CMD_CREATE: begin
               mem_waddr = free_slot.slot[IDX_W-1:0];
               mem_wdata.limit = new_limit;
               mem_wdata.count = '0;
               if (free_slot.found) begin
                  mem_we                = 1'b1;
                  in_use_in[mem_waddr]  = 1'b1;
                  rsp_item_in.handle    = free_slot.slot;
               end else begin
                  rsp_item_in.status = ST_FULL;
               end
            end
            CMD_DESTROY: begin
               if (idx_ok) begin
                  in_use_in[idx] = 1'b0;
               end
            end
            CMD_SEND: begin
               mem_wdata.count = rd_ff.count + 1'b1;
               if (!live) begin
                  rsp_item_in.status = ST_INVALID;
               end else if (rd_ff.count >= rd_ff.limit) begin
                  rsp_item_in.status = ST_BLOCK;
               end else begin
                  mem_we = 1'b1;
               end
            end
            CMD_RECEIVE: begin
               mem_wdata.count = rd_ff.count - 1'b1;
               if (!live) begin
                  rsp_item_in.status = ST_INVALID;
               end else if (rd_ff.count == '0) begin
                  rsp_item_in.status = ST_BLOCK;
               end else begin
                  mem_we = 1'b1;
               end
            end
            default: begin
               rsp_item_in.status = ST_OK;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // an item occupies exactly one update cycle
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held for more than one cycle");

   // every accepted item yields a result strobe after its update cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe_ff)
      else $error("accepted item produced no result");

   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_item_ff.status != ST_OK |-> rsp_item_ff.handle == '0)
      else $error("handle non-zero on a failed item");

   a_create_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && req_ff.command == CMD_CREATE && rsp_item_ff.status == ST_OK
      |-> in_use_ff[rsp_item_ff.handle[IDX_W-1:0]])
      else $error("created slot not marked in use");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_item_ff.status == ST_FULL |-> &in_use_ff)
      else $error("no free slot reported with a slot free");

endmodule

FILE: src/mpct_free_finder.sv
// two-level lowest-free-slot search over the in-use bits, group stage registered
module mpct_free_finder import mpct_pkg::*; #(
   parameter int LIVE = HANDLE_SPACE
) (
   input  logic              clock,
   input  logic [LIVE-1:0]   in_use,
   output free_slot_type     free_slot
);

   localparam int NGRP   = (LIVE + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PAD    = NGRP * GROUP_SIZE;

   logic [LIVE-1:0]    free_bits;
   logic [PAD-1:0]     free_pad;
   logic [NGRP-1:0]    grp_any_in;
   logic [GROUP_W-1:0] grp_low_in [NGRP];
   logic [NGRP-1:0]    grp_any_ff;
   logic [GROUP_W-1:0] grp_low_ff [NGRP];
   logic [NGRP_W-1:0]  sel_grp;
   logic [GROUP_W-1:0] sel_low;
   logic               found;

   assign free_bits = ~in_use;
   assign free_pad  = PAD'(free_bits);

   // first level: any free and lowest free inside each group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |free_pad[g*GROUP_SIZE +: GROUP_SIZE];
         grp_low_in[g] = '0;
         for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (free_pad[g*GROUP_SIZE + b]) begin
               grp_low_in[g] = GROUP_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_low_ff <= grp_low_in;
   end

   // second level: lowest group holding a free slot
   always_comb begin
      found   = |grp_any_ff;
      sel_grp = '0;
      sel_low = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel_grp = NGRP_W'(g);
            sel_low = grp_low_ff[g];
         end
      end
   end

   assign free_slot.found = found;
   assign free_slot.slot  = found ? HANDLE_W'({sel_grp, sel_low}) : '0;

endmodule
